// File: sv/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// shared types, constants and register reset values for the 4x4 transform
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int unsigned NumRows  = 4;
  localparam int unsigned NumCols  = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned PairW    = ProdW + 1;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned ShW      = SumW - FracW;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgSelW  = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned ModeW    = 2;

  localparam logic [ModeW-1:0] ModeHomog = 2'd0;
  localparam logic [ModeW-1:0] ModePoint = 2'd1;
  localparam int unsigned      ModeDirBit = 1;

  typedef logic signed [DataW-1:0] q16_t;

  localparam q16_t OneQ16 = 32'sh0001_0000;
  localparam q16_t MaxQ16 = 32'sh7fff_ffff;
  localparam q16_t MinQ16 = 32'sh8000_0000;

  typedef struct packed {
    logic valid;
    logic dir;
  } lane_ctrl_t;

  // identity matrix after reset
  function automatic logic [CfgW-1:0] cfg_reset_val(input logic [CfgSelW-1:0] sel);
    logic [CfgW-1:0] val;
    case (sel)
      3'd0:    val = 64'h0000_0000_0001_0000;
      3'd2:    val = 64'h0001_0000_0000_0000;
      3'd5:    val = 64'h0000_0000_0001_0000;
      3'd7:    val = 64'h0001_0000_0000_0000;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: sv/m4vt_cfg.sv
// ----------------------------------------------------------------------------
// m4vt_cfg
// matrix register file, two Q16.16 entries per 64-bit register
// ----------------------------------------------------------------------------
module m4vt_cfg import m4vt_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [CfgIdxW-1:0]                cfg_idx_i,
  input  logic [CfgW-1:0]                   cfg_wdata_i,
  output q16_t [NumRows-1:0][NumCols-1:0]   matrix_o
);

  logic [CfgW-1:0] cfg_q [NumCfg];
  logic            wr_hit;

  assign wr_hit = cfg_we_i && (cfg_idx_i < CfgIdxW'(NumCfg));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) begin
        cfg_q[i] <= cfg_reset_val(CfgSelW'(i));
      end
    end else if (wr_hit) begin
      cfg_q[cfg_idx_i[CfgSelW-1:0]] <= cfg_wdata_i;
    end
  end

  // even column in the low word, odd column in the high word
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumCols; c++) begin
        matrix_o[r][c] = cfg_q[r * 2 + c / 2][(c % 2) * DataW +: DataW];
      end
    end
  end

endmodule

// File: sv/m4vt_lane.sv
// ----------------------------------------------------------------------------
// m4vt_lane
// one matrix row: four products, two-level adder, floor shift and saturation
// ----------------------------------------------------------------------------
module m4vt_lane import m4vt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  q16_t [NumCols-1:0]      row_i,
  input  q16_t [NumCols-1:0]      vec_i,
  output lane_ctrl_t              ctrl_o,
  output q16_t                    res_o,
  output logic                    sat_o
);

  lane_ctrl_t                ctrl1_q, ctrl2_q, ctrl3_q;
  logic signed [ProdW-1:0]   prod_d [NumCols];
  logic signed [ProdW-1:0]   prod_q [NumCols];
  logic signed [PairW-1:0]   pair_d [2];
  logic signed [PairW-1:0]   pair_q [2];
  logic signed [SumW-1:0]    sum;
  logic        [ShW-1:0]     sh;
  logic                      hi_zero, hi_ones;
  q16_t                      res_d, res_q;
  logic                      sat_d, sat_q;

  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      prod_d[c] = row_i[c] * vec_i[c];
    end
  end

  assign pair_d[0] = PairW'(prod_q[0]) + PairW'(prod_q[1]);
  assign pair_d[1] = PairW'(prod_q[2]) + PairW'(prod_q[3]);

  // exact sum, then floor shift by the fraction width
  assign sum     = SumW'(pair_q[0]) + SumW'(pair_q[1]);
  assign sh      = sum[SumW-1:FracW];
  assign hi_zero = ~|sh[ShW-1:DataW-1];
  assign hi_ones = &sh[ShW-1:DataW-1];

  always_comb begin
    sat_d = 1'b0;
    res_d = sh[DataW-1:0];
    if (!hi_zero && !hi_ones) begin
      sat_d = 1'b1;
      res_d = sh[ShW-1] ? MinQ16 : MaxQ16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumCols; c++) begin
      prod_q[c] <= prod_d[c];
    end
    pair_q[0] <= pair_d[0];
    pair_q[1] <= pair_d[1];
    res_q     <= res_d;
    sat_q     <= sat_d;
  end

  assign ctrl_o = ctrl3_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

`ifndef NO_ASSERTIONS
  a_lane_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.valid |-> ##3 ctrl_o.valid)
    else $error("lane lost a transaction");

  a_lane_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.valid && sat_o) |-> (res_o == MaxQ16 || res_o == MinQ16))
    else $error("saturated lane result not at a limit");

  a_lane_dir_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.valid |-> ctrl_o.dir == $past(ctrl_i.dir, 3))
    else $error("direction bit misaligned with lane data");
`endif

endmodule

// File: sv/m4vt_merge.sv
// ----------------------------------------------------------------------------
// m4vt_merge
// combines the row lanes into one result and registers the result ports
// ----------------------------------------------------------------------------
module m4vt_merge import m4vt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lane_ctrl_t           ctrl_i,
  input  q16_t [NumRows-1:0]   res_i,
  input  logic [NumRows-1:0]   sat_i,
  output logic                 done_o,
  output q16_t                 x_out_o,
  output q16_t                 y_out_o,
  output q16_t                 z_out_o,
  output q16_t                 w_out_o,
  output logic                 saturated_o
);

  logic done_q;
  q16_t x_q, y_q, z_q, w_q;
  logic sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  // direction mode drops row 3 from both the result and the flag
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      x_q   <= res_i[0];
      y_q   <= res_i[1];
      z_q   <= res_i[2];
      w_q   <= ctrl_i.dir ? '0 : res_i[3];
      sat_q <= (|sat_i[2:0]) | (~ctrl_i.dir & sat_i[3]);
    end
  end

  assign done_o      = done_q;
  assign x_out_o     = x_q;
  assign y_out_o     = y_q;
  assign z_out_o     = z_q;
  assign w_out_o     = w_q;
  assign saturated_o = sat_q;

`ifndef NO_ASSERTIONS
  a_merge_dir_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.valid && ctrl_i.dir) |=> (done_o && w_out_o == '0))
    else $error("direction transaction without zero w");

  a_merge_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (x_out_o == MaxQ16 || x_out_o == MinQ16 || y_out_o == MaxQ16 ||
       y_out_o == MinQ16 || z_out_o == MaxQ16 || z_out_o == MinQ16 ||
       w_out_o == MaxQ16 || w_out_o == MinQ16))
    else $error("saturation flag with no clipped component");
`endif

endmodule

// File: sv/matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// 4x4 signed Q16.16 matrix times vector, homogeneous, point and direction modes
// ----------------------------------------------------------------------------
// One transaction is accepted every clock cycle (busy stays low) and its
// result appears on the output ports with done_o high for one cycle. Four
// row lanes, each with four 32x32 multipliers and a two-level adder, run
// in parallel; each result passes through the product, pair-sum,
// final-sum/saturate and output register stages.
// Results cannot be held off, so the receiver must take every done_o cycle.
// Matrix registers are written through cfg_we_i at any edge and reset to the
// identity matrix; write them only while no transaction is in flight.
module matrix4_vector_transform import m4vt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic [ModeW-1:0]    mode_i,
  input  q16_t                x_in_i,
  input  q16_t                y_in_i,
  input  q16_t                z_in_i,
  input  q16_t                w_in_i,
  output logic                done_o,
  output q16_t                x_out_o,
  output q16_t                y_out_o,
  output q16_t                z_out_o,
  output q16_t                w_out_o,
  output logic                saturated_o
);

  q16_t [NumRows-1:0][NumCols-1:0] matrix;
  q16_t [NumCols-1:0]              vec;
  lane_ctrl_t                      ctrl_in;
  lane_ctrl_t [NumRows-1:0]        lane_ctrl;
  q16_t [NumRows-1:0]              lane_res;
  logic [NumRows-1:0]              lane_sat;
  logic                            dir;
  q16_t                            w_eff;

  assign busy = 1'b0;
  assign dir  = mode_i[ModeDirBit];

  always_comb begin
    w_eff = w_in_i;
    if (mode_i == ModePoint) begin
      w_eff = OneQ16;
    end else if (dir) begin
      w_eff = '0;
    end
  end

  assign vec[0] = x_in_i;
  assign vec[1] = y_in_i;
  assign vec[2] = z_in_i;
  assign vec[3] = w_eff;

  assign ctrl_in.valid = start && !busy;
  assign ctrl_in.dir   = dir;

  m4vt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .matrix_o    (matrix)
  );

  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    m4vt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_in),
      .row_i  (matrix[r]),
      .vec_i  (vec),
      .ctrl_o (lane_ctrl[r]),
      .res_o  (lane_res[r]),
      .sat_o  (lane_sat[r])
    );
  end

  m4vt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl[0]),
    .res_i       (lane_res),
    .sat_i       (lane_sat),
    .done_o      (done_o),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .z_out_o     (z_out_o),
    .w_out_o     (w_out_o),
    .saturated_o (saturated_o)
  );

`ifndef NO_ASSERTIONS
  a_top_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl[0] == lane_ctrl[NumRows-1])
    else $error("row lanes out of step");

  a_top_homog_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_i == ModeHomog) |-> vec[NumCols-1] == w_in_i)
    else $error("homogeneous mode altered w");

  a_top_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("accepted transaction produced no result");
`endif

endmodule

// File: dv/tb_matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// tb_matrix4_vector_transform
// self-checking bench for the 4x4 Q16.16 matrix by vector transform
// ----------------------------------------------------------------------------
// Loads a series of matrices through the register port while the block is
// idle: identity, half, full-scale positive and negative, zero, small and
// random entries. Each setting also gets a write to an unused register index,
// which must leave the matrix unchanged. A short directed set covers every
// mode, the field extremes, unit w, floor rounding, saturation in both
// directions and direction mode with a huge w. Random vectors follow, with
// the sender running back to back or idling at random. A scoreboard class
// keeps its own copy of the matrix, computes each expected result at full
// precision and compares every done_o transaction field by field.
// ----------------------------------------------------------------------------
module tb_matrix4_vector_transform;
  import m4vt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ModeW-1:0] ModeDir      = 2'd2;
  localparam logic [ModeW-1:0] ModeDirAlias = 2'd3;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 222;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 10;

  typedef enum int {
    MatIdentity, MatHalf, MatMax, MatMin, MatZero, MatSmall, MatFull
  } mat_kind_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    q16_t             x;
    q16_t             y;
    q16_t             z;
    q16_t             w;
  } vertex_in_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
    q16_t w;
    logic sat;
  } vertex_out_t;

  class xform_scoreboard;
    q16_t        mat[NumRows][NumCols];
    vertex_out_t expected_q[$];
    int          errors;
    int          n_results;
    int          n_noted;
    int          n_dir;
    int          n_sat;

    function new();
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < NumCols; c++) begin
          mat[r][c] = (r == c) ? OneQ16 : '0;
        end
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      int r;
      int c;
      r = idx / 2;
      c = (idx % 2) * 2;
      if (idx < NumCfg) begin
        mat[r][c]     = data[DataW-1:0];
        mat[r][c + 1] = data[CfgW-1:DataW];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // exact dot product, floor shift, clip to 32 bits
    function q16_t row_dot(int r, q16_t v[NumCols], int ncols, inout bit sat);
      logic signed [SumW-1:0]  acc;
      logic signed [ProdW-1:0] prod;
      logic signed [ShW-1:0]   scaled;
      acc = '0;
      for (int c = 0; c < ncols; c++) begin
        prod = mat[r][c] * v[c];
        acc  = acc + prod;
      end
      scaled = ShW'(acc >>> FracW);
      if (scaled > MaxQ16) begin
        sat = 1'b1;
        return MaxQ16;
      end else if (scaled < MinQ16) begin
        sat = 1'b1;
        return MinQ16;
      end
      return q16_t'(scaled);
    endfunction

    function void note_vertex(vertex_in_t t);
      q16_t        v[NumCols];
      vertex_out_t res;
      bit          dir;
      bit          sat;
      int          ncols;
      dir   = t.mode[ModeDirBit];
      ncols = dir ? NumCols - 1 : NumCols;
      sat   = 1'b0;
      v[0]  = t.x;
      v[1]  = t.y;
      v[2]  = t.z;
      v[3]  = (t.mode == ModePoint) ? OneQ16 : t.w;
      res.x = row_dot(0, v, ncols, sat);
      res.y = row_dot(1, v, ncols, sat);
      res.z = row_dot(2, v, ncols, sat);
      res.w = dir ? '0 : row_dot(3, v, NumCols, sat);
      res.sat = sat;
      expected_q.push_back(res);
      n_noted++;
      if (dir) n_dir++;
      if (sat) n_sat++;
    endfunction

    function void check_vertex(vertex_out_t got);
      vertex_out_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("[%0t] unexpected result x=%h y=%h z=%h w=%h sat=%b",
                   $realtime, got.x, got.y, got.z, got.w, got.sat);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.w !== want.w || got.sat !== want.sat) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("[%0t] mismatch exp x=%h y=%h z=%h w=%h sat=%b",
                   $realtime, want.x, want.y, want.z, want.w, want.sat);
          $display("[%0t]          got x=%h y=%h z=%h w=%h sat=%b",
                   $realtime, got.x, got.y, got.z, got.w, got.sat);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic [ModeW-1:0]   mode_i      = ModeHomog;
  q16_t               x_in_i      = '0;
  q16_t               y_in_i      = '0;
  q16_t               z_in_i      = '0;
  q16_t               w_in_i      = '0;
  logic               done_o;
  q16_t               x_out_o;
  q16_t               y_out_o;
  q16_t               z_out_o;
  q16_t               w_out_o;
  logic               saturated_o;

  xform_scoreboard xform = new();
  int              n_sent;
  int              n_settings;

  matrix4_vector_transform uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .z_in_i      (z_in_i),
    .w_in_i      (w_in_i),
    .done_o      (done_o),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .z_out_o     (z_out_o),
    .w_out_o     (w_out_o),
    .saturated_o (saturated_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        xform.note_vertex('{mode_i, x_in_i, y_in_i, z_in_i, w_in_i});
      end
      if (done_o) begin
        xform.check_vertex('{x_out_o, y_out_o, z_out_o, w_out_o, saturated_o});
      end
    end
  end

  function automatic q16_t rand_q16();
    case ($urandom_range(3))
      0: return q16_t'($urandom);
      1: return q16_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: begin
        case ($urandom_range(4))
          0:       return MaxQ16;
          1:       return MinQ16;
          2:       return '0;
          3:       return OneQ16;
          default: return -OneQ16;
        endcase
      end
      default: return q16_t'(int'($urandom_range(0, 2 ** 24)) - 2 ** 23);
    endcase
  endfunction

  function automatic q16_t mat_entry(mat_kind_e k, int r, int c);
    case (k)
      MatIdentity: return (r == c) ? OneQ16 : '0;
      MatHalf:     return OneQ16 >>> 1;
      MatMax:      return MaxQ16;
      MatMin:      return MinQ16;
      MatZero:     return '0;
      MatSmall:    return q16_t'(int'($urandom_range(0, 2 ** 18)) - 2 ** 17);
      default:     return rand_q16();
    endcase
  endfunction

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    xform.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // all eight row registers, then a write to an unused index
  task automatic load_matrix(mat_kind_e k);
    logic [CfgW-1:0]    word;
    logic [CfgIdxW-1:0] idx;
    for (int i = 0; i < NumCfg; i++) begin
      word = {mat_entry(k, i / 2, (i % 2) * 2 + 1), mat_entry(k, i / 2, (i % 2) * 2)};
      write_cfg(CfgIdxW'(i), word);
    end
    idx = CfgIdxW'($urandom_range(NumCfg, 2 ** CfgIdxW - 1));
    write_cfg(idx, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_vertex(logic [ModeW-1:0] md, q16_t x, q16_t y, q16_t z, q16_t w);
    start  <= 1'b1;
    mode_i <= md;
    x_in_i <= x;
    y_in_i <= y;
    z_in_i <= z;
    w_in_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (xform.n_results < n_sent) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      send_vertex(ModeW'($urandom_range(3)), rand_q16(), rand_q16(), rand_q16(),
                  rand_q16());
    end
    start <= 1'b0;
  endtask

  task automatic run_directed();
    // identity from reset
    send_vertex(ModeHomog, MaxQ16, MinQ16, '0, OneQ16);
    send_vertex(ModeHomog, MinQ16, MaxQ16, -32'sd1, MaxQ16);
    send_vertex(ModePoint, 32'sd1, -32'sd1, 32'sh1234_5678, MinQ16);
    send_vertex(ModeDir, MaxQ16, MinQ16, OneQ16, MaxQ16);
    send_vertex(ModeDirAlias, MinQ16, OneQ16, MaxQ16, MinQ16);
    send_vertex(ModeHomog, 32'sh0003_8000, -32'sh0002_4000, 32'sh7000_0001, OneQ16);
    start <= 1'b0;
    wait_drained();
    // half entries: odd lsb products round toward minus infinity
    load_matrix(MatHalf);
    send_vertex(ModeHomog, -32'sd1, '0, '0, '0);
    send_vertex(ModeHomog, 32'sd1, '0, '0, '0);
    send_vertex(ModeHomog, -32'sd1, -32'sd1, '0, 32'sd1);
    send_vertex(ModeDir, 32'sd16, 32'sd16, 32'sd16, MaxQ16);
    send_vertex(ModeHomog, MaxQ16, MaxQ16, MaxQ16, MaxQ16);
    send_vertex(ModePoint, -32'sd3, 32'sd5, -OneQ16, MaxQ16);
    start <= 1'b0;
    wait_drained();
    load_matrix(MatMax);
    send_vertex(ModeHomog, MaxQ16, MaxQ16, MaxQ16, MaxQ16);
    send_vertex(ModeHomog, MinQ16, MinQ16, MinQ16, MinQ16);
    send_vertex(ModeDir, MinQ16, '0, '0, MaxQ16);
    send_vertex(ModePoint, '0, '0, '0, MinQ16);
    start <= 1'b0;
    wait_drained();
    // sums of most negative entries times most negative inputs overflow 64 bits
    load_matrix(MatMin);
    send_vertex(ModeHomog, MinQ16, MinQ16, MinQ16, MinQ16);
    send_vertex(ModeDirAlias, MinQ16, MinQ16, MinQ16, '0);
    start <= 1'b0;
  endtask

  initial begin : main
    mat_kind_e phase_kind[NumPhases];
    int        idle_pct[3];
    phase_kind = '{MatSmall, MatFull, MatMax, MatSmall, MatMin, MatZero, MatFull,
                   MatIdentity};
    idle_pct   = '{0, 87, 13};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      load_matrix(phase_kind[p]);
      run_random(PhaseItems, idle_pct[p % 3]);
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (xform.pending() != 0) begin
      $display("%0d expected results never arrived", xform.pending());
    end
    $display("covered %0d vectors over %0d matrix settings, all four mode codes",
             xform.n_noted, n_settings);
    $display("%0d results saturated, %0d in direction mode, %0d mismatches",
             xform.n_sat, xform.n_dir, xform.errors);
    if (xform.errors == 0 && xform.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transaction for %0d cycles", WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/m4vt_pkg.sv
sv/m4vt_cfg.sv
sv/m4vt_lane.sv
sv/m4vt_merge.sv
sv/matrix4_vector_transform.sv
dv/tb_matrix4_vector_transform.sv
